// ===== rtl/tap_tempo_estimator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Tap tempo estimator assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_ESTIMATOR_TOP_ASSERT_SVH
`define TAP_TEMPO_ESTIMATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define TTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tap tempo assertion failed");
// checked during reset too
`define TTE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tap tempo assertion failed");
`else
`define TTE_ASSERT(lbl, prop)
`define TTE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// tte_pkg
// Types and constants of the tap tempo estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;

  localparam logic [15:0] BPM_NUMERATOR  = 16'd60000;
  localparam logic [7:0]  BPM_MAX        = 8'd240;
  localparam logic [15:0] MAX_GAP_RESET  = 16'd1500;
  localparam logic [15:0] MIN_GAP_RESET  = 16'd250;

  // register indexes (paddr[2])
  localparam logic REG_MAX_GAP = 1'b0;
  localparam logic REG_MIN_GAP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } tte_state_e;

endpackage

`default_nettype wire

// ===== rtl/tap_tempo_estimator_top.sv =====
// ----------------------------------------------------------------------------
// tap_tempo_estimator_top
// Tap tempo estimator: tap gaps are averaged and turned into BPM with a
// restoring divider.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+--------------------------------
//   in      | in  | in_valid_i / in_ready_o   | in_op_i, in_now_ms_i
//   out     | out | out_valid_o / out_ready_i | out_tempo_set_o, out_ext_clk_o, _bpm_o
//   cfg     | in  | APB psel/penable/pwrite   | paddr, pwdata, prdata
//
// A tap that sets a tempo goes through accept, evaluate, multiply, the divider
// (one quotient bit per cycle, skipped when the gap sum is zero) and output.
// Any other word goes from evaluate straight to output. in_ready_o is high
// only while the sequencer is idle; a finished word waits in the output register,
// and the sequencer holds in its output state only if that register is still full.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_tempo_estimator_top #(
  parameter int unsigned COUNT_BITS = tte_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input words
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        in_op_i,
  input  wire logic [31:0]                 in_now_ms_i,
  // result words
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             out_tempo_set_o,
  output logic                             out_ext_clk_o,
  output logic [7:0]                       out_tempo_bpm_o,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tte_pkg::PADDR_W-1:0] paddr,
  input  wire logic [tte_pkg::PDATA_W-1:0] pwdata,
  output logic [tte_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  import tte_pkg::*;

`include "tap_tempo_estimator_top_assert.svh"

  localparam int unsigned PROD_W = COUNT_BITS + 16;
  localparam int unsigned CNT_W  = $clog2(PROD_W);

  tte_state_e state_q, state_d;

  logic [15:0]           max_gap_q, min_gap_q;
  logic [31:0]           now_q, now_d;
  logic                  op_q, op_d;
  logic [31:0]           delta_q, delta_d;
  logic [31:0]           last_q, last_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [31:0]           sum_q, sum_d;
  logic                  resolved_q, resolved_d;
  logic [PROD_W-1:0]     num_q, num_d;
  logic [31:0]           rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  res_set_q, res_set_d;
  logic                  res_ext_q, res_ext_d;
  logic                  res_tap_q, res_tap_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_set_q, out_set_d;
  logic                  out_ext_q, out_ext_d;
  logic [7:0]            out_bpm_q, out_bpm_d;

  logic                  in_acc;
  logic                  short_gap;
  logic                  stale;
  logic [31:0]           gap;
  logic [32:0]           sum_ext;
  logic [32:0]           rem_sh;
  logic [32:0]           rem_sub;
  logic [7:0]            bpm_sat;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q <= MAX_GAP_RESET;
      min_gap_q <= MIN_GAP_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MAX_GAP: max_gap_q <= pwdata[15:0];
        REG_MIN_GAP: min_gap_q <= pwdata[15:0];
        default:     max_gap_q <= max_gap_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_GAP: prdata = {16'b0, max_gap_q};
      REG_MIN_GAP: prdata = {16'b0, min_gap_q};
      default:     prdata = '0;
    endcase
  end

  // datapath terms
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign short_gap  = delta_q < {16'b0, max_gap_q};
  assign stale      = delta_q > {15'b0, max_gap_q, 1'b0};
  assign gap        = (delta_q < {16'b0, min_gap_q}) ? {16'b0, min_gap_q} : delta_q;
  assign sum_ext    = {1'b0, sum_q} + {1'b0, gap};
  assign rem_sh     = {rem_q, num_q[PROD_W-1]};
  assign rem_sub    = rem_sh - {1'b0, sum_q};
  assign bpm_sat    = (num_q > PROD_W'(BPM_MAX)) ? BPM_MAX : num_q[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      resolved_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      resolved_q  <= resolved_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    op_q      <= op_d;
    delta_q   <= delta_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    res_set_q <= res_set_d;
    res_ext_q <= res_ext_d;
    res_tap_q <= res_tap_d;
    out_set_q <= out_set_d;
    out_ext_q <= out_ext_d;
    out_bpm_q <= out_bpm_d;
  end

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    op_d        = op_q;
    delta_d     = delta_q;
    last_d      = last_q;
    count_d     = count_q;
    sum_d       = sum_q;
    resolved_d  = resolved_q;
    num_d       = num_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    res_set_d   = res_set_q;
    res_ext_d   = res_ext_q;
    res_tap_d   = res_tap_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_set_d   = out_set_q;
    out_ext_d   = out_ext_q;
    out_bpm_d   = out_bpm_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = in_op_i;
          now_d   = in_now_ms_i;
          delta_d = in_now_ms_i - last_q;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        res_set_d = 1'b0;
        res_ext_d = 1'b0;
        res_tap_d = 1'b0;
        state_d   = ST_DONE;
        if (op_q) begin
          last_d = now_q;
          if (short_gap) begin
            if (count_q != '1) begin
              count_d = count_q + 1'b1;
              sum_d   = sum_ext[32] ? '1 : sum_ext[31:0];
            end
            resolved_d = 1'b1;
            res_set_d  = 1'b1;
            res_tap_d  = 1'b1;
            state_d    = ST_MUL;
          end else begin
            resolved_d = 1'b0;
            count_d    = '0;
            sum_d      = '0;
          end
        end else if (!resolved_q && stale) begin
          res_set_d  = 1'b1;
          res_ext_d  = 1'b1;
          resolved_d = 1'b1;
        end
      end
      ST_MUL: begin
        rem_d = '0;
        cnt_d = CNT_W'(PROD_W - 1);
        if (sum_q == '0) begin
          num_d   = PROD_W'(BPM_MAX);
          state_d = ST_DONE;
        end else begin
          num_d   = PROD_W'(count_q) * PROD_W'(BPM_NUMERATOR);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring divide, quotient bits shift in where numerator bits leave
        if (!rem_sub[32]) begin
          rem_d = rem_sub[31:0];
          num_d = {num_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[31:0];
          num_d = {num_q[PROD_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_set_d   = res_set_q;
          out_ext_d   = res_ext_q;
          out_bpm_d   = res_tap_q ? bpm_sat : 8'd0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign out_tempo_set_o = out_set_q;
  assign out_ext_clk_o   = out_ext_q;
  assign out_tempo_bpm_o = out_bpm_q;

  `TTE_ASSERT(a_ext_bpm, out_valid_o && out_ext_clk_o |-> out_tempo_set_o && out_tempo_bpm_o == '0)
  `TTE_ASSERT(a_bpm_range, out_valid_o |-> out_tempo_bpm_o <= BPM_MAX)
  `TTE_ASSERT(a_accept_eval, in_valid_i && in_ready_o |=> state_q == ST_EVAL)
  `TTE_ASSERT_ALWAYS(a_rem_below_sum, state_q == ST_DIV |-> rem_q < sum_q)

endmodule

`default_nettype wire

// ===== tb/tap_tempo_estimator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_tempo_estimator_top_tb
// Drives tap and time-check words into the estimator over valid/ready. A
// scoreboard keeps its own copy of the run state, works out each expected
// tempo word, and checks the result words in order. The run covers several
// gap settings, random idling on both channels, and a long receiver stall.
// ----------------------------------------------------------------------------

localparam logic OP_TICK = 1'b0;
localparam logic OP_TAP  = 1'b1;

typedef struct packed {
  logic       set;
  logic       ext;
  logic [7:0] bpm;
} tempo_word_t;

class tempo_tracker;
  logic [15:0] max_gap;
  logic [15:0] min_gap;
  logic [15:0] count_cap;
  logic [31:0] last_tap;
  logic [15:0] taps;
  logic [31:0] gap_total;
  bit          resolved;
  tempo_word_t tempo_due[$];
  int unsigned errors;

  function new(int unsigned cw);
    count_cap = 16'((32'd1 << cw) - 32'd1);
    max_gap   = tte_pkg::MAX_GAP_RESET;
    min_gap   = tte_pkg::MIN_GAP_RESET;
    last_tap  = '0;
    taps      = '0;
    gap_total = '0;
    resolved  = 1'b1;
    errors    = 0;
  endfunction

  function void set_reg(logic idx, logic [15:0] value);
    if (idx == tte_pkg::REG_MAX_GAP) max_gap = value;
    else min_gap = value;
  endfunction

  // accepted input word: advance the run state, queue the tempo word it yields
  function void note_word(logic op, logic [31:0] now);
    logic [31:0] gap;
    logic [32:0] acc;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    tempo_word_t w;
    w = '0;
    gap = now - last_tap;
    if (op == OP_TAP) begin
      if (gap < {16'h0, max_gap}) begin
        if (gap < {16'h0, min_gap}) gap = {16'h0, min_gap};
        // count and sum freeze once the count saturates
        if (taps < count_cap) begin
          acc = {1'b0, gap_total} + {1'b0, gap};
          gap_total = acc[32] ? '1 : acc[31:0];
          taps = taps + 16'd1;
        end
        if (gap_total == '0) begin
          w.bpm = tte_pkg::BPM_MAX;
        end else begin
          num = 64'(taps);
          num = num * tte_pkg::BPM_NUMERATOR;
          den = 64'(gap_total);
          quo = num / den;
          w.bpm = (quo > tte_pkg::BPM_MAX) ? tte_pkg::BPM_MAX : quo[7:0];
        end
        w.set = 1'b1;
        resolved = 1'b1;
      end else begin
        resolved  = 1'b0;
        taps      = '0;
        gap_total = '0;
      end
      last_tap = now;
    end else if (!resolved && ({1'b0, gap} > {16'h0, max_gap, 1'b0})) begin
      // stale open run falls back to the external clock
      w.set = 1'b1;
      w.ext = 1'b1;
      resolved = 1'b1;
    end
    tempo_due.push_back(w);
  endfunction

  function void check_word(logic set, logic ext, logic [7:0] bpm);
    tempo_word_t exp_w;
    if (tempo_due.size() == 0) begin
      $display("%0t: unexpected result word set=%0b ext=%0b bpm=%0d", $time, set, ext, bpm);
      errors++;
      return;
    end
    exp_w = tempo_due.pop_front();
    if (set !== exp_w.set) begin
      $display("%0t: tempo_set mismatch: expected %0b, actual %0b", $time, exp_w.set, set);
      errors++;
    end
    if (ext !== exp_w.ext) begin
      $display("%0t: ext_clk mismatch: expected %0b, actual %0b",
               $time, exp_w.ext, ext);
      errors++;
    end
    if (bpm !== exp_w.bpm) begin
      $display("%0t: tempo_bpm mismatch: expected %0d, actual %0d", $time, exp_w.bpm, bpm);
      errors++;
    end
  endfunction
endclass

module tap_tempo_estimator_top_tb;
  import tte_pkg::*;

  localparam int unsigned CNT_W       = COUNT_BITS_DEF;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned BLOCK_WORDS = 55;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               in_op_i     = 1'b0;
  logic [31:0]        in_now_ms_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               out_tempo_set_o;
  logic               out_ext_clk_o;
  logic [7:0]         out_tempo_bpm_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tempo_tracker sb;
  int unsigned  snd_idle_pct = 19;
  int unsigned  rcv_idle_pct = 88;
  bit           hold_req     = 1'b0;
  logic [31:0]  tap_ref      = '0;
  int unsigned  words_sent   = 0;

  tap_tempo_estimator_top #(.COUNT_BITS(CNT_W)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_op_i        (in_op_i),
    .in_now_ms_i    (in_now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_tempo_set_o(out_tempo_set_o),
    .out_ext_clk_o  (out_ext_clk_o),
    .out_tempo_bpm_o(out_tempo_bpm_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_word(input logic op, input logic [31:0] now);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_op_i     <= op;
    in_now_ms_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(op, now);
    if (op == OP_TAP) tap_ref = now;
    words_sent++;
  endtask

  // write, then read back
  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== value) begin
      $display("%0t: register %0d readback mismatch: expected %0d, actual %0d",
               $time, idx, value, prdata[15:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.tempo_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [15:0] max_ms, input logic [15:0] min_ms);
    wait_idle();
    write_reg(REG_MAX_GAP, max_ms);
    write_reg(REG_MIN_GAP, min_ms);
  endtask

  function automatic logic [31:0] short_gap();
    logic [31:0] top;
    top = {16'h0, sb.max_gap} - 32'd1;
    case ($urandom_range(7))
      0: return 32'd0;
      1: return top;
      2: return ({16'h0, sb.min_gap} <= top) ? {16'h0, sb.min_gap} : top;
      3: return ({16'h0, sb.min_gap} - 32'd1 <= top) ? {16'h0, sb.min_gap} - 32'd1 : 32'd0;
      default: return $urandom_range(top, 0);
    endcase
  endfunction

  function automatic logic [31:0] long_gap();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: return {16'h0, sb.max_gap};
      1: return {16'h0, sb.max_gap} + $urandom_range(4000, 0);
      default: return (v < {16'h0, sb.max_gap}) ? {16'h0, sb.max_gap} : v;
    endcase
  endfunction

  // time-check offset from the last tap, clustered on the stale bound
  function automatic logic [31:0] tick_offset();
    logic [31:0] lim;
    lim = {15'h0, sb.max_gap, 1'b0};
    case ($urandom_range(4))
      0: return lim;
      1: return lim + 32'd1;
      2: return $urandom_range(lim, 0);
      3: return lim + $urandom_range(5000, 0);
      default: return $urandom;
    endcase
  endfunction

  // open a run, maybe let it go stale, then tap out a tempo
  task automatic send_run();
    int unsigned n;
    send_word(OP_TAP, tap_ref + long_gap());
    repeat ($urandom_range(2, 0)) send_word(OP_TICK, tap_ref + tick_offset());
    n = $urandom_range(12, 1);
    repeat (n) begin
      if ($urandom_range(5) == 0) send_word(OP_TICK, tap_ref + tick_offset());
      send_word(OP_TAP, tap_ref + short_gap());
    end
  endtask

  task automatic random_block(input int unsigned count);
    int unsigned base;
    base = words_sent;
    while (words_sent - base < count) begin
      if ($urandom_range(9) == 0) send_word(1'($urandom_range(1, 0)), $urandom);
      else send_run();
    end
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_word(out_tempo_set_o, out_ext_clk_o, out_tempo_bpm_o);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    sb = new(CNT_W);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at the reset gap settings
    send_word(OP_TICK, 32'd0);            // nothing open, no change
    send_word(OP_TAP, 32'd100);           // short gap raised to the floor
    send_word(OP_TAP, 32'd100);           // zero gap
    send_word(OP_TAP, 32'd1599);          // one below the run limit
    send_word(OP_TAP, 32'd3099);          // gap exactly at the limit opens a run
    send_word(OP_TICK, 32'd6099);         // exactly twice the limit, not stale
    send_word(OP_TICK, 32'd6100);         // stale: external marker
    send_word(OP_TICK, 32'd13099);        // already resolved
    send_word(OP_TAP, 32'hFFFF_FF00);
    send_word(OP_TAP, 32'h0000_0010);     // gap across the wrap
    send_word(OP_TAP, 32'h0000_010A);     // gap exactly the floor
    send_word(OP_TAP, 32'h0000_0203);     // one below the floor
    send_word(OP_TICK, 32'hFFFF_FFFF);
    send_word(OP_TAP, 32'hFFFF_FFFF);
    send_word(OP_TICK, 32'd3000);         // stale across the wrap
    send_word(OP_TAP, 32'h5555_5555);
    send_word(OP_TAP, 32'hAAAA_AAAA);
    send_word(OP_TICK, 32'hAAAA_AAAB);
    send_word(OP_TICK, 32'h0000_0000);
    send_word(OP_TAP, 32'hAAAA_AD02);     // single gap tempo

    apply_setting(MAX_GAP_RESET, MIN_GAP_RESET);
    random_block(BLOCK_WORDS);

    // receiver stalls long while words keep coming
    apply_setting(16'd1, 16'd65535);
    hold_req = 1'b1;
    random_block(BLOCK_WORDS);

    snd_idle_pct = 88;
    rcv_idle_pct = 19;
    apply_setting(16'd65535, 16'd250);
    random_block(BLOCK_WORDS);
    apply_setting(16'd700, 16'd400);
    random_block(BLOCK_WORDS);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    // one long unbroken run of short taps
    apply_setting(16'd3000, 16'd250);
    send_word(OP_TAP, tap_ref + 32'd3000);
    repeat (262) send_word(OP_TAP, tap_ref + $urandom_range(2999, 0));
    apply_setting(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 250)));
    random_block(BLOCK_WORDS);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.tempo_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
